// ===== sv/krxwc_pkg.sv =====
// Shared types, constants and helper functions of the keyed rotate-xor word cipher.
package krxwc_pkg;

    localparam int WORD_W      = 32;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int ROT_W       = 5;
    localparam int KEY_BYTES   = 64;
    localparam int KEY_WORDS   = KEY_BYTES / 4;
    localparam int TAIL_MAX    = 3;

    localparam logic [WORD_W-1:0] WORD_ADD  = 32'h6E58A5C2;
    localparam logic [7:0]        TAIL_ADD  = 8'h52;
    localparam logic [3:0]        ROT_FOLD  = 4'hD;
    localparam logic [ROT_W-1:0]  ROT_BASE  = 5'd8;
    localparam logic [POS_W-1:0]  TAIL_STEP = 6'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_MASK  = 1'b0,
        REG_KEY_DELTA = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_DECRYPT = 1'b0,
        OP_ENCRYPT = 1'b1
    } op_t;

    typedef logic [KEY_BYTES-1:0][7:0] key_bytes_t;

    // Key view handed from the register block to the transform.
    typedef struct packed {
        key_bytes_t        key_bytes;
        logic [ROT_W-1:0]  rot_amount;
        logic [POS_W-1:0]  delta;
    } key_view_t;

    localparam logic [7:0] BASE_KEY [KEY_BYTES] = '{
        8'h5E, 8'h4A, 8'h0D, 8'h4D, 8'hE1, 8'hF3, 8'hAB, 8'hB3,
        8'h6D, 8'h33, 8'h37, 8'h3C, 8'hF3, 8'hF5, 8'hC3, 8'h86,
        8'h89, 8'h9B, 8'h4F, 8'h7D, 8'h11, 8'hDE, 8'hD7, 8'h58,
        8'h8D, 8'h77, 8'h67, 8'h63, 8'h29, 8'h46, 8'hF3, 8'hA5,
        8'hB5, 8'hA4, 8'h7F, 8'h06, 8'h42, 8'hE7, 8'h0A, 8'hED,
        8'hCC, 8'h50, 8'h94, 8'hB1, 8'h5A, 8'h4A, 8'h20, 8'hE7,
        8'hF5, 8'h04, 8'hAF, 8'hD9, 8'h7F, 8'h68, 8'h3B, 8'h5D,
        8'hFD, 8'hA6, 8'hC7, 8'hC1, 8'h89, 8'h22, 8'h50, 8'hFC
    };

    // Gather four key bytes starting at idx, wrapping past the table end.
    function automatic logic [WORD_W-1:0] gather(input key_bytes_t kb,
                                                 input logic [POS_W-1:0] idx);
        logic [WORD_W-1:0] r;
        logic [POS_W-1:0]  p;
        r = '0;
        for (int b = 0; b < 4; b++)
        begin
            p = POS_W'(idx + POS_W'(b));
            r[8*b +: 8] = kb[p];
        end
        return r;
    endfunction

endpackage

// ===== sv/krxwc_key_regs.sv =====
// Configuration registers, masked key table and rotate amount.
module krxwc_key_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [krxwc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [krxwc_pkg::WORD_W-1:0]         cfg_data,
    output krxwc_pkg::key_view_t                 key_view
);

    logic [krxwc_pkg::WORD_W-1:0] key_mask_reg;
    logic [krxwc_pkg::POS_W-1:0]  key_delta_reg;
    logic [3:0]                   fold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mask_reg  <= '0;
            key_delta_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (krxwc_pkg::cfg_reg_t'(cfg_index))
                krxwc_pkg::REG_KEY_MASK:  key_mask_reg  <= cfg_data;
                krxwc_pkg::REG_KEY_DELTA: key_delta_reg <= cfg_data[krxwc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Add the mask to each table word; fold the mask nibbles for the rotate.
    always_comb
    begin
        logic [krxwc_pkg::WORD_W-1:0] w;
        for (int i = 0; i < krxwc_pkg::KEY_WORDS; i++)
        begin
            w = {krxwc_pkg::BASE_KEY[4*i+3], krxwc_pkg::BASE_KEY[4*i+2],
                 krxwc_pkg::BASE_KEY[4*i+1], krxwc_pkg::BASE_KEY[4*i]} + key_mask_reg;
            for (int b = 0; b < 4; b++)
            begin
                key_view.key_bytes[4*i+b] = w[8*b +: 8];
            end
        end
        fold = krxwc_pkg::ROT_FOLD;
        for (int n = 0; n < 8; n++)
        begin
            fold = fold ^ key_mask_reg[4*n +: 4];
        end
        key_view.rot_amount = krxwc_pkg::ROT_BASE + {1'b0, fold};
        key_view.delta      = key_delta_reg;
    end

endmodule

// ===== sv/krxwc_xform.sv =====
// Combinational word and tail transform for one item.
module krxwc_xform
(
    input  krxwc_pkg::key_view_t                 key_view,
    input  logic                                 op,
    input  logic [krxwc_pkg::POS_W-1:0]          byte_position,
    input  logic [krxwc_pkg::WORD_W-1:0]         data_word,
    input  logic [krxwc_pkg::COUNT_W-1:0]        tail_count,
    output logic [krxwc_pkg::WORD_W-1:0]         result_word
);

    logic [krxwc_pkg::POS_W-1:0]    k_base;
    logic [krxwc_pkg::WORD_W-1:0]   k_word;
    logic [2*krxwc_pkg::WORD_W-1:0] dbl_l;
    logic [2*krxwc_pkg::WORD_W-1:0] dbl_r;
    logic [krxwc_pkg::WORD_W-1:0]   full_res;
    logic [krxwc_pkg::WORD_W-1:0]   tail_res;

    assign k_base = krxwc_pkg::POS_W'(byte_position + key_view.delta);
    assign k_word = krxwc_pkg::gather(key_view.key_bytes, k_base);

    // Decrypt: xor, add, rotate left. Encrypt: rotate right, subtract, xor.
    always_comb
    begin
        dbl_l = {data_word ^ k_word, data_word ^ k_word};
        dbl_l = {dbl_l[krxwc_pkg::WORD_W-1:0] + krxwc_pkg::WORD_ADD,
                 dbl_l[krxwc_pkg::WORD_W-1:0] + krxwc_pkg::WORD_ADD};
        dbl_l = dbl_l << key_view.rot_amount;
        dbl_r = {data_word, data_word} >> key_view.rot_amount;
        if (op == krxwc_pkg::OP_ENCRYPT)
        begin
            full_res = (dbl_r[krxwc_pkg::WORD_W-1:0] - krxwc_pkg::WORD_ADD) ^ k_word;
        end
        else
        begin
            full_res = dbl_l[2*krxwc_pkg::WORD_W-1:krxwc_pkg::WORD_W];
        end
    end

    // Each tail byte takes its own key word, shifted by a nibble count.
    always_comb
    begin
        logic [krxwc_pkg::WORD_W-1:0]  kw;
        logic [krxwc_pkg::POS_W-1:0]   idx;
        logic [krxwc_pkg::COUNT_W-1:0] tt;
        logic [3:0]                    shamt;
        logic [7:0]                    a;
        logic [7:0]                    b;
        tail_res = '0;
        for (int t = 0; t < krxwc_pkg::TAIL_MAX; t++)
        begin
            tt    = krxwc_pkg::COUNT_W'(t);
            idx   = krxwc_pkg::POS_W'(k_base + krxwc_pkg::POS_W'(krxwc_pkg::TAIL_STEP * tt));
            kw    = krxwc_pkg::gather(key_view.key_bytes, idx);
            shamt = {krxwc_pkg::COUNT_W'(tail_count - tt), 2'b00};
            a     = 8'(kw >> shamt);
            b     = data_word[8*t +: 8];
            if (tt < tail_count)
            begin
                if (op == krxwc_pkg::OP_ENCRYPT)
                begin
                    tail_res[8*t +: 8] = a ^ (b - krxwc_pkg::TAIL_ADD);
                end
                else
                begin
                    tail_res[8*t +: 8] = (a ^ b) + krxwc_pkg::TAIL_ADD;
                end
            end
        end
    end

    assign result_word = (tail_count == '0) ? full_res : tail_res;

endmodule

// ===== sv/keyed_rotate_xor_word_cipher_core.sv =====
// Top level of the keyed rotate-xor word cipher: input register, transform, result register.
//
// One beat in carries a 32-bit little-endian buffer word (tail_count zero) or a tail of one
// to three bytes in the low bytes, with its byte offset modulo 64 and the direction in op.
// One beat out carries the transformed word; unused tail bytes come out zero. The block
// takes one beat every clock while in_stall is low. The beat lands in the input register,
// the key gather, add, xor and rotate run as combinational logic into the result register,
// and that register holds the answer until the sink takes it. The result register and
// the input register each stage one beat, so a stalled sink backs up the input only
// when both are full. The user writes key_mask (index 0) and key_delta (index 1) through
// cfg_write while no beat is in flight; the block does not enforce it. Both reset to zero.
module keyed_rotate_xor_word_cipher_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [krxwc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [krxwc_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [krxwc_pkg::POS_W-1:0]          byte_position,
    input  logic [krxwc_pkg::WORD_W-1:0]         data_word,
    input  logic [krxwc_pkg::COUNT_W-1:0]        tail_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [krxwc_pkg::WORD_W-1:0]         result_word
);

    krxwc_pkg::key_view_t           key_view;

    logic                           s1_valid_reg;
    logic                           op_reg;
    logic [krxwc_pkg::POS_W-1:0]    pos_reg;
    logic [krxwc_pkg::WORD_W-1:0]   data_reg;
    logic [krxwc_pkg::COUNT_W-1:0]  count_reg;

    logic                           out_valid_reg;
    logic [krxwc_pkg::WORD_W-1:0]   result_reg;
    logic [krxwc_pkg::WORD_W-1:0]   result_next;

    logic                           s2_ready;
    logic                           s1_ready;
    logic                           in_take;

    krxwc_key_regs u_key_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_view  (key_view)
    );

    krxwc_xform u_xform
    (
        .key_view      (key_view),
        .op            (op_reg),
        .byte_position (pos_reg),
        .data_word     (data_reg),
        .tail_count    (count_reg),
        .result_word   (result_next)
    );

    // The result register frees up when empty or when its beat leaves this edge.
    assign s2_ready = !out_valid_reg || !out_stall;
    // The input register frees up when empty or when its beat advances.
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;

    // Advance control: load a new beat, or drop the stage when its beat moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: capture the input beat, then the transformed word; hold while stalled.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= op;
            pos_reg   <= byte_position;
            data_reg  <= data_word;
            count_reg <= tail_count;
        end
        if (s2_ready && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;

endmodule

// ===== tb/keyed_rotate_xor_word_cipher_checker.sv =====
// Channel monitor, result predictor and comparator for the keyed rotate-xor word cipher.
`timescale 1ns / 100ps

module keyed_rotate_xor_word_cipher_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [krxwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [krxwc_pkg::WORD_W-1:0]      cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              op,
    input  logic [krxwc_pkg::POS_W-1:0]       byte_position,
    input  logic [krxwc_pkg::WORD_W-1:0]      data_word,
    input  logic [krxwc_pkg::COUNT_W-1:0]     tail_count,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [krxwc_pkg::WORD_W-1:0]      result_word,
    output int                                mismatches,
    output int                                outstanding
);

    localparam logic [31:0] WORD_OFFSET  = 32'h6E58A5C2;
    localparam logic [7:0]  TAIL_OFFSET  = 8'h52;

    localparam logic [7:0] KEY_TABLE [64] = '{
        8'h5E, 8'h4A, 8'h0D, 8'h4D, 8'hE1, 8'hF3, 8'hAB, 8'hB3,
        8'h6D, 8'h33, 8'h37, 8'h3C, 8'hF3, 8'hF5, 8'hC3, 8'h86,
        8'h89, 8'h9B, 8'h4F, 8'h7D, 8'h11, 8'hDE, 8'hD7, 8'h58,
        8'h8D, 8'h77, 8'h67, 8'h63, 8'h29, 8'h46, 8'hF3, 8'hA5,
        8'hB5, 8'hA4, 8'h7F, 8'h06, 8'h42, 8'hE7, 8'h0A, 8'hED,
        8'hCC, 8'h50, 8'h94, 8'hB1, 8'h5A, 8'h4A, 8'h20, 8'hE7,
        8'hF5, 8'h04, 8'hAF, 8'hD9, 8'h7F, 8'h68, 8'h3B, 8'h5D,
        8'hFD, 8'hA6, 8'hC7, 8'hC1, 8'h89, 8'h22, 8'h50, 8'hFC
    };

    typedef struct {
        logic [31:0]     word;
        krxwc_pkg::op_t  dir;
        logic [5:0]      pos;
        logic [31:0]     data;
        logic [1:0]      count;
    } cipher_beat_t;

    logic [31:0]  key_mask;
    logic [5:0]   key_delta;
    cipher_beat_t expected_words [$];

    // masked table byte; the add carries across the whole table word
    function automatic logic [7:0] masked_key_byte(input logic [5:0] idx);
        logic [31:0] w;
        int          base;
        base = {idx[5:2], 2'b00};
        w = {KEY_TABLE[base + 3], KEY_TABLE[base + 2], KEY_TABLE[base + 1], KEY_TABLE[base]};
        w = w + key_mask;
        return w[8 * idx[1:0] +: 8];
    endfunction

    function automatic logic [31:0] key_word_at(input logic [5:0] pos);
        logic [5:0]  start;
        logic [5:0]  idx;
        logic [31:0] r;
        start = pos + key_delta;
        r = '0;
        for (int b = 0; b < 4; b++)
        begin
            idx = start + 6'(b);
            r[8 * b +: 8] = masked_key_byte(idx);
        end
        return r;
    endfunction

    function automatic logic [4:0] rotate_amount();
        logic [3:0] x;
        x = '0;
        for (int n = 0; n < 8; n++)
            x = x ^ key_mask[4 * n +: 4];
        return 5'd8 + 5'(x ^ 4'hD);
    endfunction

    function automatic logic [31:0] cipher_word_of(input krxwc_pkg::op_t dir,
                                                   input logic [5:0] pos,
                                                   input logic [31:0] data,
                                                   input logic [1:0] count);
        logic [31:0] kw;
        logic [31:0] rot;
        logic [31:0] res;
        logic [4:0]  r;
        logic [7:0]  a;
        logic [7:0]  b;
        int          n;
        res = '0;
        n = int'(count);
        if (n == 0)
        begin
            kw = key_word_at(pos);
            r = rotate_amount();
            if (dir == krxwc_pkg::OP_ENCRYPT)
            begin
                rot = (data >> r) | (data << (32 - r));
                res = (rot - WORD_OFFSET) ^ kw;
            end
            else
            begin
                rot = (data ^ kw) + WORD_OFFSET;
                res = (rot << r) | (rot >> (32 - r));
            end
        end
        else
        begin
            // bytes at and above the count stay zero
            for (int t = 0; t < n; t++)
            begin
                kw = key_word_at(pos + 6'(4 * t));
                a = 8'(kw >> (4 * (n - t)));
                b = data[8 * t +: 8];
                if (dir == krxwc_pkg::OP_ENCRYPT)
                    res[8 * t +: 8] = a ^ (b - TAIL_OFFSET);
                else
                    res[8 * t +: 8] = (a ^ b) + TAIL_OFFSET;
            end
        end
        return res;
    endfunction

    // print one line, count it
    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cipher_beat_t beat;
        cipher_beat_t want;
        if (!rst_n)
        begin
            key_mask    = '0;
            key_delta   = '0;
            mismatches  = 0;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                beat.dir   = krxwc_pkg::op_t'(op);
                beat.pos   = byte_position;
                beat.data  = data_word;
                beat.count = tail_count;
                beat.word  = cipher_word_of(beat.dir, beat.pos, beat.data, beat.count);
                expected_words.push_back(beat);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("result_word %h with no beat pending", result_word));
                else
                begin
                    want = expected_words.pop_front();
                    if (result_word !== want.word)
                        report_mismatch($sformatf(
                            "result_word %h, expected %h (%s pos %0d data %h count %0d)",
                            result_word, want.word, want.dir.name(), want.pos, want.data,
                            want.count));
                end
            end
            if (cfg_write)
            begin
                case (krxwc_pkg::cfg_reg_t'(cfg_index))
                    krxwc_pkg::REG_KEY_MASK:  key_mask  = cfg_data;
                    krxwc_pkg::REG_KEY_DELTA: key_delta = cfg_data[5:0];
                    default: ;
                endcase
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== tb/keyed_rotate_xor_word_cipher_core_tb.sv =====
// Stimulus, pacing and verdict for the keyed rotate-xor word cipher core.
`timescale 1ns / 100ps

module keyed_rotate_xor_word_cipher_core_tb;

    localparam int RESET_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_SETTLE     = 4;
    localparam int ITEMS_PER_PHASE  = 140;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              cfg_write     = 1'b0;
    logic [krxwc_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [krxwc_pkg::WORD_W-1:0]      cfg_data      = '0;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic                              op            = 1'b0;
    logic [krxwc_pkg::POS_W-1:0]       byte_position = '0;
    logic [krxwc_pkg::WORD_W-1:0]      data_word     = '0;
    logic [krxwc_pkg::COUNT_W-1:0]     tail_count    = '0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic [krxwc_pkg::WORD_W-1:0]      result_word;

    int mismatches;
    int outstanding;

    // pacing knobs, set per phase by the stimulus process
    int source_idle_pct = 0;
    int sink_stall_pct  = 0;
    bit long_hold_req   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    keyed_rotate_xor_word_cipher_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .byte_position (byte_position),
        .data_word     (data_word),
        .tail_count    (tail_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_word   (result_word)
    );

    keyed_rotate_xor_word_cipher_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .byte_position (byte_position),
        .data_word     (data_word),
        .tail_count    (tail_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_word   (result_word),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result sink. Stall at the phase's rate; on request, hold off for a long
    // stretch counted here so the sender keeps pushing beats while both the
    // result register and the input register fill and in_stall rises.
    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Present one beat and hold it, unchanged, until the core takes it.
    task automatic send_beat(input krxwc_pkg::op_t dir,
                             input logic [krxwc_pkg::POS_W-1:0] pos,
                             input logic [krxwc_pkg::WORD_W-1:0] data,
                             input logic [krxwc_pkg::COUNT_W-1:0] count);
        in_valid      <= 1'b1;
        op            <= dir;
        byte_position <= pos;
        data_word     <= data;
        tail_count    <= count;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Insert sender gaps after a beat. Drop valid only when a gap cycle
    // actually follows, so valid is never lowered and raised in one step.
    task automatic pace_source();
        while ($urandom_range(99) < source_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected result has come back, then
    // let the pipeline settle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Write one register; call only with no beat in flight.
    task automatic write_reg(input krxwc_pkg::cfg_reg_t idx,
                             input logic [krxwc_pkg::WORD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // About half full words, the rest tails of one to three bytes with
    // random garbage in the unused upper bytes.
    task automatic send_random();
        krxwc_pkg::op_t                dir;
        logic [krxwc_pkg::COUNT_W-1:0] count;
        dir = krxwc_pkg::op_t'($urandom_range(1));
        if ($urandom_range(1))
            count = '0;
        else
            count = krxwc_pkg::COUNT_W'($urandom_range(3, 1));
        send_beat(dir, krxwc_pkg::POS_W'($urandom_range(63)), $urandom, count);
    endtask

    // One phase: settle the key, set pacing, stream random beats. Optionally
    // trigger the long sink hold-off early on, or pause the sender midway
    // until every result is back.
    task automatic run_phase(input logic [krxwc_pkg::WORD_W-1:0] mask,
                             input logic [krxwc_pkg::POS_W-1:0] delta,
                             input int src_pct, input int sink_pct,
                             input bit long_hold, input bit mid_pause);
        wait_for_results();
        write_reg(krxwc_pkg::REG_KEY_MASK, mask);
        write_reg(krxwc_pkg::REG_KEY_DELTA, krxwc_pkg::WORD_W'(delta));
        source_idle_pct = src_pct;
        sink_stall_pct  = sink_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            if (long_hold && i == 10)
                long_hold_req = 1'b1;
            if (mid_pause && i == ITEMS_PER_PHASE / 2)
                wait_for_results();
            send_random();
            pace_source();
        end
    endtask

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset key: both directions, every tail
        // count, all-ones and all-zero data, and positions at the table end
        // so the gather wraps (tails step by four and wrap too). All-ones
        // data on tails also checks that unused bytes are ignored and zeroed.
        for (int d = 0; d < 2; d++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                send_beat(krxwc_pkg::op_t'(d), 6'd63, 32'hFFFF_FFFF,
                          krxwc_pkg::COUNT_W'(c));
                send_beat(krxwc_pkg::op_t'(d), 6'd0, 32'h0000_0000,
                          krxwc_pkg::COUNT_W'(c));
            end
        end
        send_beat(krxwc_pkg::OP_ENCRYPT, 6'd61, 32'hA5A5_A5A5, 2'd0);
        send_beat(krxwc_pkg::OP_DECRYPT, 6'd60, 32'h5A5A_5A5A, 2'd3);
        send_beat(krxwc_pkg::OP_ENCRYPT, 6'd32, 32'hDEAD_BEEF, 2'd2);
        send_beat(krxwc_pkg::OP_DECRYPT, 6'd62, 32'h1234_5678, 2'd1);

        // Key settings: all-ones mask with the largest shift, masks that give
        // the shortest and longest rotate, random keys, and the all-zero mask.
        run_phase(32'hFFFF_FFFF, 6'd63, 0, 0, 1'b0, 1'b0);
        run_phase(32'h0000_000D, 6'd1, 86, 0, 1'b0, 1'b0);
        run_phase(32'h0000_0002, 6'd62, 0, 86, 1'b0, 1'b0);
        run_phase($urandom, krxwc_pkg::POS_W'($urandom_range(63)), 12, 12, 1'b0, 1'b1);
        run_phase($urandom, 6'd0, 0, 0, 1'b1, 1'b0);
        run_phase($urandom, krxwc_pkg::POS_W'($urandom_range(63)), 86, 0, 1'b0, 1'b0);
        run_phase($urandom, krxwc_pkg::POS_W'($urandom_range(63)), 0, 86, 1'b1, 1'b0);
        run_phase(32'h0000_0000, 6'd32, 12, 12, 1'b0, 1'b0);

        wait_for_results();
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("keyed_rotate_xor_word_cipher_core regression: pass");
        else
            $display("keyed_rotate_xor_word_cipher_core regression: fail");
        $finish;
    end

    // Watchdog: end a hung run well past the slowest legal one.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("keyed_rotate_xor_word_cipher_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/krxwc_pkg.sv
sv/krxwc_key_regs.sv
sv/krxwc_xform.sv
sv/keyed_rotate_xor_word_cipher_core.sv
tb/keyed_rotate_xor_word_cipher_checker.sv
tb/keyed_rotate_xor_word_cipher_core_tb.sv
